// File: src/bls_pkg.sv
// Shared types and constants for the Bresenham line stepper.
package bls_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int DIM_W = 12;
    localparam int ADDR_W = 22;
    localparam int COLOR_W = 24;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_SEL_BIT = 2;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET = 12'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_FRAME_WIDTH = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_sel_t;

endpackage

// File: src/bresenham_line_stepper.sv
// Bresenham line stepper top level: line state, pixel generation and output skid stage.

// A load beat (opcode 0) latches two signed endpoints and a color and gives no
// result; each step beat (opcode 1) while a line is active gives one pixel with
// its coordinates, its linear address x + frame_width * y (zero outside the
// frame), an inside flag, the color and a last flag at the endpoint, and then
// advances the error term unless it ends the line. The block takes one beat per
// clock cycle while in_stall is low: the error update is a single add and compare
// on the line registers. A result, its address from the one 12 by 12 multiplier,
// is registered in the output register or, while that is held, in the skid
// register, which absorbs one result, so in_stall rises only after out_stall has
// held back two results. The user must write frame width and height through the
// APB port at byte addresses 0 and 4 while no line is in flight; nothing enforces it.
module bresenham_line_stepper #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bls_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bls_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bls_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic signed [COORD_BITS-1:0]    start_x,
    input  logic signed [COORD_BITS-1:0]    start_y,
    input  logic signed [COORD_BITS-1:0]    end_x,
    input  logic signed [COORD_BITS-1:0]    end_y,
    input  logic [bls_pkg::COLOR_W-1:0]     line_color,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [COORD_BITS-1:0]    pixel_x,
    output logic signed [COORD_BITS-1:0]    pixel_y,
    output logic [bls_pkg::ADDR_W-1:0]      pixel_address,
    output logic                            inside_frame,
    output logic [bls_pkg::COLOR_W-1:0]     pixel_color,
    output logic                            last_pixel
);

    localparam int SPAN_W = COORD_BITS + 1;
    localparam int ERR_W = COORD_BITS + 3;
    localparam int E2_W = COORD_BITS + 4;
    localparam int DIM_W = bls_pkg::DIM_W;
    localparam int ADDR_W = bls_pkg::ADDR_W;
    localparam int COLOR_W = bls_pkg::COLOR_W;

    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;

    logic signed [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic signed [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic signed [COORD_BITS-1:0] target_x_reg, target_x_next;
    logic signed [COORD_BITS-1:0] target_y_reg, target_y_next;
    logic signed [SPAN_W-1:0]     span_x_reg, span_x_next;
    logic signed [SPAN_W-1:0]     span_y_neg_reg, span_y_neg_next;
    logic                         step_x_neg_reg, step_x_neg_next;
    logic                         step_y_neg_reg, step_y_neg_next;
    logic signed [ERR_W-1:0]      err_reg, err_next;
    logic [COLOR_W-1:0]           color_reg, color_next;
    logic                         active_reg, active_next;

    logic                         accept;
    logic                         is_step;
    logic                         res_valid;

    logic signed [SPAN_W-1:0]     load_dx;
    logic signed [SPAN_W-1:0]     load_dy;
    logic signed [SPAN_W-1:0]     load_span_x;
    logic signed [SPAN_W-1:0]     load_span_y_neg;

    logic signed [E2_W-1:0]       e2;
    logic                         move_x;
    logic                         move_y;
    logic signed [ERR_W-1:0]      err_add_x;
    logic signed [ERR_W-1:0]      err_add_y;

    logic [ADDR_W-1:0]            x_ext;
    logic [ADDR_W-1:0]            y_ext;
    logic [2*DIM_W-1:0]           row_offset;
    logic                         res_inside;
    logic                         res_last;
    logic [ADDR_W-1:0]            res_addr;

    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] out_x_reg;
    logic signed [COORD_BITS-1:0] out_y_reg;
    logic [ADDR_W-1:0]            out_addr_reg;
    logic                         out_inside_reg;
    logic [COLOR_W-1:0]           out_color_reg;
    logic                         out_last_reg;

    logic                         skid_valid_reg;
    logic signed [COORD_BITS-1:0] skid_x_reg;
    logic signed [COORD_BITS-1:0] skid_y_reg;
    logic [ADDR_W-1:0]            skid_addr_reg;
    logic                         skid_inside_reg;
    logic [COLOR_W-1:0]           skid_color_reg;
    logic                         skid_last_reg;

    logic                         out_free;
    logic                         cfg_write;
    logic                         cfg_sel;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel = paddr[bls_pkg::REG_SEL_BIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= bls_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= bls_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                bls_pkg::REG_FRAME_WIDTH:  frame_width_reg <= pwdata[DIM_W-1:0];
                bls_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[DIM_W-1:0];
                default:                   frame_width_reg <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            bls_pkg::REG_FRAME_WIDTH:  prdata = bls_pkg::APB_DATA_W'(frame_width_reg);
            bls_pkg::REG_FRAME_HEIGHT: prdata = bls_pkg::APB_DATA_W'(frame_height_reg);
            default:                   prdata = '0;
        endcase
    end

    // Input handshake.
    assign in_stall = skid_valid_reg;
    assign accept = in_valid && !in_stall;
    assign is_step = (opcode == bls_pkg::OP_STEP);
    assign res_valid = accept && is_step && active_reg;

    // Line setup for a load beat.
    assign load_dx = SPAN_W'(end_x) - SPAN_W'(start_x);
    assign load_dy = SPAN_W'(end_y) - SPAN_W'(start_y);
    assign load_span_x = load_dx[SPAN_W-1] ? -load_dx : load_dx;
    assign load_span_y_neg = load_dy[SPAN_W-1] ? load_dy : -load_dy;

    // Pixel at the current position.
    assign x_ext = ADDR_W'(unsigned'(pos_x_reg));
    assign y_ext = ADDR_W'(unsigned'(pos_y_reg));
    assign row_offset = frame_width_reg * y_ext[DIM_W-1:0];
    assign res_inside = !pos_x_reg[COORD_BITS-1] && !pos_y_reg[COORD_BITS-1]
                        && (x_ext < ADDR_W'(frame_width_reg))
                        && (y_ext < ADDR_W'(frame_height_reg));
    assign res_last = (pos_x_reg == target_x_reg) && (pos_y_reg == target_y_reg);
    assign res_addr = res_inside ? (x_ext + row_offset[ADDR_W-1:0]) : '0;

    // Error term advance.
    assign e2 = E2_W'(err_reg) <<< 1;
    assign move_x = e2 > E2_W'(span_y_neg_reg);
    assign move_y = e2 < E2_W'(span_x_reg);
    assign err_add_x = move_x ? ERR_W'(span_y_neg_reg) : '0;
    assign err_add_y = move_y ? ERR_W'(span_x_reg) : '0;

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        target_x_next = target_x_reg;
        target_y_next = target_y_reg;
        span_x_next = span_x_reg;
        span_y_neg_next = span_y_neg_reg;
        step_x_neg_next = step_x_neg_reg;
        step_y_neg_next = step_y_neg_reg;
        err_next = err_reg;
        color_next = color_reg;
        active_next = active_reg;

        if (accept && !is_step)
        begin
            pos_x_next = start_x;
            pos_y_next = start_y;
            target_x_next = end_x;
            target_y_next = end_y;
            span_x_next = load_span_x;
            span_y_neg_next = load_span_y_neg;
            step_x_neg_next = !(start_x < end_x);
            step_y_neg_next = !(start_y < end_y);
            err_next = ERR_W'(load_span_x) + ERR_W'(load_span_y_neg);
            color_next = line_color;
            active_next = 1'b1;
        end
        else if (res_valid)
        begin
            if (res_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                err_next = err_reg + err_add_x + err_add_y;
                if (move_x)
                begin
                    pos_x_next = step_x_neg_reg ? pos_x_reg - COORD_BITS'(1)
                                                : pos_x_reg + COORD_BITS'(1);
                end
                if (move_y)
                begin
                    pos_y_next = step_y_neg_reg ? pos_y_reg - COORD_BITS'(1)
                                                : pos_y_reg + COORD_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            target_x_reg <= '0;
            target_y_reg <= '0;
            span_x_reg <= '0;
            span_y_neg_reg <= '0;
            step_x_neg_reg <= 1'b0;
            step_y_neg_reg <= 1'b0;
            err_reg <= '0;
            color_reg <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            target_x_reg <= target_x_next;
            target_y_reg <= target_y_next;
            span_x_reg <= span_x_next;
            span_y_neg_reg <= span_y_neg_next;
            step_x_neg_reg <= step_x_neg_next;
            step_y_neg_reg <= step_y_neg_next;
            err_reg <= err_next;
            color_reg <= color_next;
            active_reg <= active_next;
        end
    end

    // Output register with one skid entry behind it.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_x_reg <= skid_x_reg;
                out_y_reg <= skid_y_reg;
                out_addr_reg <= skid_addr_reg;
                out_inside_reg <= skid_inside_reg;
                out_color_reg <= skid_color_reg;
                out_last_reg <= skid_last_reg;
            end
        end
        else if (res_valid)
        begin
            if (out_free)
            begin
                out_x_reg <= pos_x_reg;
                out_y_reg <= pos_y_reg;
                out_addr_reg <= res_addr;
                out_inside_reg <= res_inside;
                out_color_reg <= color_reg;
                out_last_reg <= res_last;
            end
            else
            begin
                skid_x_reg <= pos_x_reg;
                skid_y_reg <= pos_y_reg;
                skid_addr_reg <= res_addr;
                skid_inside_reg <= res_inside;
                skid_color_reg <= color_reg;
                skid_last_reg <= res_last;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_x = out_x_reg;
    assign pixel_y = out_y_reg;
    assign pixel_address = out_addr_reg;
    assign inside_frame = out_inside_reg;
    assign pixel_color = out_color_reg;
    assign last_pixel = out_last_reg;

    // The skid entry only fills behind a held output beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
    else $error("skid entry valid without a valid output beat");

    // A step at the endpoint ends the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_last) |=> !active_reg)
    else $error("line still active after its last pixel");

    // Pixels outside the frame carry a zero address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_inside_reg) |-> (out_addr_reg == '0))
    else $error("nonzero address on a pixel outside the frame");

    // Results only come from steps taken while a line is active.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !skid_valid_reg && !active_reg) |=> !skid_valid_reg)
    else $error("skid entry filled without an active line");

endmodule
